FILE: rtl/trapezoidal_trajectory_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoidal trajectory generator
// Clocked, reset-qualified property checks shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_TRAJECTORY_GENERATOR_ASSERT_SVH
`define TRAPEZOIDAL_TRAJECTORY_GENERATOR_ASSERT_SVH

// The property must hold at every rising edge outside of reset.
`define TTG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a rising edge outside of reset.
`define TTG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ttg_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal trajectory generator package
// Field widths, register and phase codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ttg_pkg;

  // Field widths.
  localparam int unsigned POS_W      = 40;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned RATE_W     = 31;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  // Signed width of the doubled coast offset 2e - 2R - C.
  localparam int unsigned D2_W       = 18;
  // Remainder bits resolved per clock by the reversal divider.
  localparam int unsigned DIV_BITS   = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POSITION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_POSITION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_TICK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_PER_TICK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_TICKS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS   = 3'd6;

  // Motion phase codes.
  localparam logic [PHASE_W-1:0] PHASE_ACCEL = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_COAST = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_DECEL = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_REST  = 3'd4;

  // Configuration register file.
  typedef struct packed {
    logic signed [POS_W-1:0] first_position;
    logic signed [POS_W-1:0] second_position;
    logic [RATE_W-1:0]       speed_per_tick;
    logic [RATE_W-1:0]       accel_per_tick_sq;
    logic [TIME_W-1:0]       ramp_ticks;
    logic [TIME_W-1:0]       coast_ticks;
    logic [TIME_W-1:0]       reverse_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_position:    40'sd0,
    second_position:   40'sd527071788,
    speed_per_tick:    31'd1677722,
    accel_per_tick_sq: 31'd67109,
    ramp_ticks:        16'd25,
    coast_ticks:       16'd289,
    reverse_ticks:     16'd500
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic seg;
    logic mul1;
    logic mul2;
    logic fin;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ttg_tick_if.sv
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel that carries one sample tick item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

FILE: rtl/ttg_ref_if.sv
// ----------------------------------------------------------------------------
// Reference channel
// Valid/ready channel that carries one motion reference item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttg_ref_if;
  logic                                valid;
  logic                                ready;
  logic signed [ttg_pkg::POS_W-1:0]    ref_position;
  logic signed [ttg_pkg::VEL_W-1:0]    ref_velocity;
  logic signed [ttg_pkg::VEL_W-1:0]    ref_acceleration;
  logic [ttg_pkg::PHASE_W-1:0]         phase;
  logic                                moving_negative;

  modport source (
    output valid, output ref_position, output ref_velocity,
    output ref_acceleration, output phase, output moving_negative,
    input ready
  );
  modport sink (
    input valid, input ref_position, input ref_velocity,
    input ref_acceleration, input phase, input moving_negative,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/ttg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ttg_pkg::CFG_IDX_W-1:0]     index;
  logic [ttg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ttg_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Decodes register writes and holds the motion profile settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ttg_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ttg_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [ttg_pkg::CFG_DATA_W-1:0]   data_i,
  output ttg_pkg::cfg_t                    cfg_o
);

  ttg_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; indexes past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        ttg_pkg::CFG_FIRST_POSITION: begin
          cfg_d.first_position = data_i[ttg_pkg::POS_W-1:0];
        end
        ttg_pkg::CFG_SECOND_POSITION: begin
          cfg_d.second_position = data_i[ttg_pkg::POS_W-1:0];
        end
        ttg_pkg::CFG_SPEED_PER_TICK: begin
          cfg_d.speed_per_tick = data_i[ttg_pkg::RATE_W-1:0];
        end
        ttg_pkg::CFG_ACCEL_PER_TICK: begin
          cfg_d.accel_per_tick_sq = data_i[ttg_pkg::RATE_W-1:0];
        end
        ttg_pkg::CFG_RAMP_TICKS: begin
          cfg_d.ramp_ticks = data_i[ttg_pkg::TIME_W-1:0];
        end
        ttg_pkg::CFG_COAST_TICKS: begin
          cfg_d.coast_ticks = data_i[ttg_pkg::TIME_W-1:0];
        end
        ttg_pkg::CFG_REVERSE_TICKS: begin
          cfg_d.reverse_ticks = data_i[ttg_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ttg_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/ttg_ctrl.sv
// ----------------------------------------------------------------------------
// Trajectory controller
// Sequences one tick through divide, segment, multiply and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoidal_trajectory_generator_assert.svh"

module ttg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ttg_pkg::dp_sts_t      sts_i,
  output ttg_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SEG  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  // Handshake qualifiers.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_SEG;
      end
      S_SEG:  state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_FIN;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.load     = in_fire;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.seg      = (state_q == S_SEG);
    cmd_o.mul1     = (state_q == S_MUL1);
    cmd_o.mul2     = (state_q == S_MUL2);
    cmd_o.fin      = (state_q == S_FIN) && out_free;
  end

  // Output valid flag: set when a result is loaded, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks.
  `TTG_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.seg, cmd_o.mul1, cmd_o.mul2, cmd_o.fin}), "more than one datapath command active")
  `TTG_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !in_ready_o, "tick item accepted while a tick is in progress")
  `TTG_ASSERT(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_FIN, "result presented without a finished tick")

endmodule

`default_nettype wire

FILE: rtl/ttg_dp.sv
// ----------------------------------------------------------------------------
// Trajectory datapath
// Tick and segment state, reversal divider, profile multipliers and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoidal_trajectory_generator_assert.svh"

module ttg_dp #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ttg_pkg::cfg_t                       cfg_i,
  input  logic                                restart_i,
  input  ttg_pkg::ctrl_cmd_t                  cmd_i,
  output ttg_pkg::dp_sts_t                    sts_o,
  output logic signed [ttg_pkg::POS_W-1:0]    ref_position_o,
  output logic signed [ttg_pkg::VEL_W-1:0]    ref_velocity_o,
  output logic signed [ttg_pkg::VEL_W-1:0]    ref_acceleration_o,
  output logic [ttg_pkg::PHASE_W-1:0]         phase_o,
  output logic                                moving_negative_o
);

  localparam int unsigned DIV_STEPS =
    (TICK_WIDTH + ttg_pkg::DIV_BITS - 1) / ttg_pkg::DIV_BITS;
  localparam int unsigned DIV_W   = DIV_STEPS * ttg_pkg::DIV_BITS;
  localparam int unsigned DCNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int unsigned CMP_W   = TICK_WIDTH + 2;
  localparam int unsigned TW      = ttg_pkg::TIME_W;
  localparam int unsigned SQ_W    = 2 * TW;
  localparam int unsigned VELP_W  = ttg_pkg::RATE_W + TW;
  localparam int unsigned MAGP_W  = ttg_pkg::RATE_W + SQ_W;
  localparam int unsigned MAG_W   = MAGP_W - 1;
  localparam int unsigned TERM_W  = ttg_pkg::RATE_W + 1 + ttg_pkg::D2_W;
  localparam int unsigned SUM_W   = MAGP_W + 2;
  localparam int unsigned POS_W   = ttg_pkg::POS_W;
  localparam int unsigned VEL_W   = ttg_pkg::VEL_W;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  // Architectural tick state.
  logic [TICK_WIDTH-1:0] tick_count_q;
  logic [TICK_WIDTH-1:0] seg_start_q;
  logic                  dir_neg_q;
  logic                  start_sec_q;

  // Per-tick working registers.
  logic [TICK_WIDTH-1:0]           tc_q;
  logic [DIV_W-1:0]                dvd_q;
  logic [TW-1:0]                   rem_q;
  logic [DCNT_W-1:0]               dcnt_q;
  logic [ttg_pkg::PHASE_W-1:0]     phase_q;
  logic [TW-1:0]                   m_q;
  logic signed [ttg_pkg::D2_W-1:0] d2_q;
  logic [SQ_W-1:0]                 sq_q;
  logic [VELP_W-1:0]               velp_q;
  logic [MAG_W-1:0]                mag_q;
  logic signed [TERM_W-1:0]        term_q;

  // Output register.
  logic signed [POS_W-1:0]         pos_out_q;
  logic signed [VEL_W-1:0]         vel_out_q;
  logic signed [VEL_W-1:0]         acc_out_q;
  logic [ttg_pkg::PHASE_W-1:0]     phase_out_q;
  logic                            neg_out_q;

  // --------------------------------------------------------------------------
  // Reversal divider: tick count modulo the reversal period, DIV_BITS per clock.
  // --------------------------------------------------------------------------
  logic [TICK_WIDTH-1:0] tc_load;
  logic [TW-1:0]         rev;
  logic [TW-1:0]         rem_n;
  logic [DIV_W-1:0]      dvd_n;
  logic [TW:0]           trial;

  assign tc_load = restart_i ? '0 : tick_count_q;
  // A zero period behaves as one tick.
  assign rev = (cfg_i.reverse_ticks == '0) ? TW'(1) : cfg_i.reverse_ticks;

  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int k = 0; k < ttg_pkg::DIV_BITS; k++) begin
      trial = {rem_n, dvd_n[DIV_W-1]};
      if (trial >= {1'b0, rev}) trial = trial - {1'b0, rev};
      rem_n = trial[TW-1:0];
      dvd_n = {dvd_n[DIV_W-2:0], 1'b0};
    end
  end

  assign sts_o.div_last = (dcnt_q == DCNT_W'(DIV_STEPS - 1));

  // --------------------------------------------------------------------------
  // Segment update, elapsed count and phase selection.
  // --------------------------------------------------------------------------
  logic                          hit;
  logic                          tc_zero;
  logic [TICK_WIDTH-1:0]         seg_n;
  logic                          dir_n;
  logic                          sis_n;
  logic [TICK_WIDTH-1:0]         elapsed;
  logic [CMP_W-1:0]              e_x;
  logic [CMP_W-1:0]              ramp_x;
  logic [CMP_W-1:0]              coast_x;
  logic [CMP_W-1:0]              ramp_end_x;
  logic [CMP_W-1:0]              seg_end_x;
  logic [CMP_W-1:0]              r_x;
  logic [CMP_W-1:0]              d2_x;
  logic [ttg_pkg::PHASE_W-1:0]   phase_n;
  logic [TW-1:0]                 m_n;

  assign hit     = (rem_q == '0);
  assign tc_zero = (tc_q == '0);
  assign seg_n   = hit ? tc_q : seg_start_q;
  // Tick zero always starts at the first position moving positive.
  assign dir_n   = tc_zero ? 1'b0 : (dir_neg_q ^ hit);
  assign sis_n   = tc_zero ? 1'b0 : (start_sec_q ^ hit);
  assign elapsed = tc_q - seg_n;

  assign e_x        = CMP_W'(elapsed);
  assign ramp_x     = CMP_W'(cfg_i.ramp_ticks);
  assign coast_x    = CMP_W'(cfg_i.coast_ticks);
  assign ramp_end_x = ramp_x + coast_x;
  assign seg_end_x  = ramp_x + ramp_x + coast_x;
  assign r_x        = seg_end_x - e_x;
  // Only meaningful while coasting, where it stays within the D2_W range.
  assign d2_x       = e_x + e_x - ramp_x - ramp_x - coast_x;

  always_comb begin
    phase_n = ttg_pkg::PHASE_REST;
    m_n     = '0;
    if (e_x < ramp_x) begin
      phase_n = ttg_pkg::PHASE_ACCEL;
      m_n     = e_x[TW-1:0];
    end else if (e_x < ramp_end_x) begin
      phase_n = ttg_pkg::PHASE_COAST;
    end else if (e_x < seg_end_x) begin
      phase_n = ttg_pkg::PHASE_DECEL;
      m_n     = r_x[TW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Control state registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      seg_start_q  <= '0;
      dir_neg_q    <= 1'b0;
      start_sec_q  <= 1'b0;
      dcnt_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (cmd_i.seg) begin
        tick_count_q <= tc_q + TICK_WIDTH'(1);
        seg_start_q  <= seg_n;
        dir_neg_q    <= dir_n;
        start_sec_q  <= sis_n;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working registers: divider, segment results and products.
  // --------------------------------------------------------------------------
  logic [MAGP_W-1:0] magp;

  assign magp = MAGP_W'(cfg_i.accel_per_tick_sq) * MAGP_W'(sq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tc_q  <= tc_load;
      dvd_q <= DIV_W'(tc_load);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
    if (cmd_i.seg) begin
      phase_q <= phase_n;
      m_q     <= m_n;
      d2_q    <= signed'(d2_x[ttg_pkg::D2_W-1:0]);
    end
    if (cmd_i.mul1) begin
      sq_q   <= SQ_W'(m_q) * SQ_W'(m_q);
      velp_q <= VELP_W'(cfg_i.accel_per_tick_sq) * VELP_W'(m_q);
    end
    if (cmd_i.mul2) begin
      mag_q  <= magp[MAGP_W-1:1];
      term_q <= TERM_W'(signed'({1'b0, cfg_i.speed_per_tick})) * TERM_W'(d2_q);
    end
  end

  // --------------------------------------------------------------------------
  // Result forming and saturation.
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] ps;
  logic signed [POS_W-1:0] pe;
  logic signed [SUM_W-1:0] ps_x;
  logic signed [SUM_W-1:0] pe_x;
  logic signed [SUM_W-1:0] mag_x;
  logic signed [SUM_W-1:0] term_x;
  logic signed [SUM_W-1:0] coast_sum;
  logic signed [SUM_W-1:0] pos_x;
  logic [SUM_W-POS_W:0]    pos_top;
  logic signed [POS_W-1:0] pos_sat;
  logic                    vel_big;
  logic signed [VEL_W-1:0] vel_small;
  logic signed [VEL_W-1:0] spd;
  logic signed [VEL_W-1:0] acc_mag;
  logic signed [VEL_W-1:0] ramp_vel;
  logic signed [VEL_W-1:0] vel_n;
  logic signed [VEL_W-1:0] acc_n;

  assign ps     = start_sec_q ? cfg_i.second_position : cfg_i.first_position;
  assign pe     = start_sec_q ? cfg_i.first_position : cfg_i.second_position;
  assign ps_x   = SUM_W'(ps);
  assign pe_x   = SUM_W'(pe);
  assign mag_x  = signed'(SUM_W'(mag_q));
  assign term_x = SUM_W'(term_q);
  // Coast position is the midpoint plus a signed offset, halved with floor.
  assign coast_sum = ps_x + pe_x + (dir_neg_q ? -term_x : term_x);

  assign vel_big   = |velp_q[VELP_W-1:VEL_W-1];
  assign vel_small = signed'({1'b0, velp_q[VEL_W-2:0]});
  assign spd       = signed'({1'b0, cfg_i.speed_per_tick});
  assign acc_mag   = signed'({1'b0, cfg_i.accel_per_tick_sq});

  // Ramp velocity magnitude saturates to the 32-bit signed range.
  always_comb begin
    if (dir_neg_q) begin
      ramp_vel = vel_big ? VEL_MIN : -vel_small;
    end else begin
      ramp_vel = vel_big ? VEL_MAX : vel_small;
    end
  end

  always_comb begin
    pos_x = pe_x;
    vel_n = '0;
    acc_n = '0;
    case (phase_q)
      ttg_pkg::PHASE_ACCEL: begin
        pos_x = dir_neg_q ? (ps_x - mag_x) : (ps_x + mag_x);
        vel_n = ramp_vel;
        acc_n = dir_neg_q ? -acc_mag : acc_mag;
      end
      ttg_pkg::PHASE_COAST: begin
        pos_x = coast_sum >>> 1;
        vel_n = dir_neg_q ? -spd : spd;
      end
      ttg_pkg::PHASE_DECEL: begin
        pos_x = dir_neg_q ? (pe_x + mag_x) : (pe_x - mag_x);
        vel_n = ramp_vel;
        acc_n = dir_neg_q ? acc_mag : -acc_mag;
      end
      default: begin
      end
    endcase
  end

  // Position saturates to the 40-bit signed range.
  assign pos_top = pos_x[SUM_W-1:POS_W-1];
  always_comb begin
    if ((&pos_top) || !(|pos_top)) begin
      pos_sat = pos_x[POS_W-1:0];
    end else begin
      pos_sat = pos_x[SUM_W-1] ? POS_MIN : POS_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      pos_out_q   <= pos_sat;
      vel_out_q   <= vel_n;
      acc_out_q   <= acc_n;
      phase_out_q <= phase_q;
      neg_out_q   <= dir_neg_q;
    end
  end

  assign ref_position_o     = pos_out_q;
  assign ref_velocity_o     = vel_out_q;
  assign ref_acceleration_o = acc_out_q;
  assign phase_o            = phase_out_q;
  assign moving_negative_o  = neg_out_q;

  // Checks.
  `TTG_ASSERT(a_tick_zero_origin, clk_i, rst_ni, (cmd_i.seg && tc_zero) |=> (!dir_neg_q && !start_sec_q && seg_start_q == '0), "tick zero did not restart at the first position")
  `TTG_ASSERT(a_reversal_flips, clk_i, rst_ni, (cmd_i.seg && hit && !tc_zero) |=> (dir_neg_q != $past(dir_neg_q) && seg_start_q == $past(tc_q)), "reversal tick did not open a new segment")
  `TTG_ASSERT(a_no_reversal_holds, clk_i, rst_ni, (cmd_i.seg && !hit && !tc_zero) |=> ($stable(seg_start_q) && $stable(dir_neg_q)), "segment changed between reversal ticks")
  `TTG_ASSERT_NEVER(a_start_tracks_dir, clk_i, rst_ni, dir_neg_q != start_sec_q, "start position and direction out of step")

endmodule

`default_nettype wire

FILE: rtl/trapezoidal_trajectory_generator.sv
// ----------------------------------------------------------------------------
// Trapezoidal trajectory generator
// Produces a position, velocity and acceleration reference per sample tick.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i carries one item per sample tick; restart clears the tick count
//   before that tick is processed. ref_o returns exactly one reference item
//   per tick: position, velocity, acceleration, phase and direction.
//   cfg_i writes the profile registers by index; it is always ready and is
//   meant to be written only while no tick is in progress.
// Tick processing:
//   After acceptance, the remainder of the tick count by the reversal period
//   is resolved 8 bits per cycle, followed by segment update, two multiplier
//   stages and result forming. A new tick is accepted only once the previous
//   one has left its last step and the controller is idle again.
// Reset and stalls:
//   Reset restores the register defaults, clears the tick count and starts
//   at the first position moving positive. A finished result waits in the
//   output register while the next tick is accepted and worked on; that
//   tick then holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_trajectory_generator #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttg_tick_if.sink    tick_i,
  ttg_ref_if.source   ref_o,
  ttg_cfg_if.sink     cfg_i
);

  ttg_pkg::cfg_t      cfg;
  ttg_pkg::ctrl_cmd_t cmd;
  ttg_pkg::dp_sts_t   sts;

  // Configuration writes are never stalled.
  assign cfg_i.ready = 1'b1;

  ttg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  ttg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (tick_i.ready),
    .out_valid_o (ref_o.valid),
    .out_ready_i (ref_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttg_dp #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .restart_i          (tick_i.restart),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .ref_position_o     (ref_o.ref_position),
    .ref_velocity_o     (ref_o.ref_velocity),
    .ref_acceleration_o (ref_o.ref_acceleration),
    .phase_o            (ref_o.phase),
    .moving_negative_o  (ref_o.moving_negative)
  );

endmodule

`default_nettype wire

FILE: bench/trapezoidal_trajectory_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoidal trajectory generator testbench
// Drives sample ticks and profile register writes into the generator and
// checks every motion reference item against a cycle-free model of the
// profile or a value from the directed table. That table comes first, then
// mostly random profiles run under idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module trapezoidal_trajectory_generator_tb;

  localparam int unsigned TICK_W       = 32;
  localparam int unsigned TICK_LATENCY = 8;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned ROUNDS       = 12;
  localparam int unsigned ROUND_TICKS  = 92;

  // Field widths taken from the package.
  localparam int unsigned POS_W      = ttg_pkg::POS_W;
  localparam int unsigned VEL_W      = ttg_pkg::VEL_W;
  localparam int unsigned RATE_W     = ttg_pkg::RATE_W;
  localparam int unsigned TIME_W     = ttg_pkg::TIME_W;
  localparam int unsigned PHASE_W    = ttg_pkg::PHASE_W;
  localparam int unsigned CFG_IDX_W  = ttg_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = ttg_pkg::CFG_DATA_W;

  // Saturation bounds of the position and of the rate outputs.
  localparam longint POS_HI = 64'sd549755813887;
  localparam longint POS_LO = -64'sd549755813888;
  localparam longint V32_HI = 64'sd2147483647;
  localparam longint V32_LO = -64'sd2147483648;

  // One motion reference item as the block returns it.
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [VEL_W-1:0] vel;
    logic signed [VEL_W-1:0] acc;
    logic [PHASE_W-1:0]      phase;
    logic                    neg;
  } motion_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

  // One row of the directed stimulus table.
  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    bit                       restart;
    bit                       typed;
    motion_t                  want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttg_tick_if tick_if ();
  ttg_ref_if  ref_if ();
  ttg_cfg_if  cfg_if ();

  trapezoidal_trajectory_generator #(
    .TICK_WIDTH(TICK_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_if),
    .ref_o  (ref_if),
    .cfg_i  (cfg_if)
  );

  // Profile registers as last written, and the tick and segment state.
  ttg_pkg::cfg_t     profile = ttg_pkg::CFG_RESET;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [TICK_W-1:0] seg_start = '0;
  bit                dir_neg = 1'b0;
  bit                from_second = 1'b0;

  motion_t expected_refs[$];
  row_t    rows[$];
  int      mismatches = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int unsigned cycles = 0;

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advances the tick state by one tick and returns the reference it yields.
  function automatic motion_t next_motion(input bit restart);
    longint unsigned rev, e, ramp, coast, span, r, mag_u, accel_u;
    longint ps, pe, pos, vel, acc, ac, sc, d2, term;
    logic [TICK_W-1:0] elapsed;
    motion_t m;
    rev = (profile.reverse_ticks == '0) ? 64'd1 : 64'(profile.reverse_ticks);
    if (restart) tick_cnt = '0;
    if (64'(tick_cnt) % rev == 0) begin
      from_second = ~from_second;
      dir_neg = ~dir_neg;
      seg_start = tick_cnt;
    end
    // Tick zero always runs from the first position in the positive direction.
    if (tick_cnt == '0) begin
      from_second = 1'b0;
      dir_neg = 1'b0;
    end
    ps = from_second ? longint'(profile.second_position)
                     : longint'(profile.first_position);
    pe = from_second ? longint'(profile.first_position)
                     : longint'(profile.second_position);
    accel_u = 64'(profile.accel_per_tick_sq);
    ac = longint'(accel_u);
    sc = longint'(64'(profile.speed_per_tick));
    ramp = 64'(profile.ramp_ticks);
    coast = 64'(profile.coast_ticks);
    elapsed = tick_cnt - seg_start;
    e = 64'(elapsed);
    span = 2 * ramp + coast;

    if (e < ramp) begin
      mag_u = (accel_u * e * e) >> 1;
      pos = dir_neg ? ps - longint'(mag_u) : ps + longint'(mag_u);
      vel = ac * longint'(e);
      if (dir_neg) vel = -vel;
      acc = dir_neg ? -ac : ac;
      m.phase = ttg_pkg::PHASE_ACCEL;
    end else if (e < ramp + coast) begin
      // Midpoint of the move plus the signed coast offset, floored.
      d2 = 2 * longint'(e) - 2 * longint'(ramp) - longint'(coast);
      term = sc * d2;
      if (dir_neg) term = -term;
      pos = (ps + pe + term) >>> 1;
      vel = dir_neg ? -sc : sc;
      acc = 0;
      m.phase = ttg_pkg::PHASE_COAST;
    end else if (e < span) begin
      r = span - e;
      mag_u = (accel_u * r * r) >> 1;
      pos = dir_neg ? pe + longint'(mag_u) : pe - longint'(mag_u);
      vel = ac * longint'(r);
      if (dir_neg) vel = -vel;
      acc = dir_neg ? ac : -ac;
      m.phase = ttg_pkg::PHASE_DECEL;
    end else begin
      pos = pe;
      vel = 0;
      acc = 0;
      m.phase = ttg_pkg::PHASE_REST;
    end

    m.pos = POS_W'(sat(pos, POS_LO, POS_HI));
    m.vel = VEL_W'(sat(vel, V32_LO, V32_HI));
    m.acc = VEL_W'(sat(acc, V32_LO, V32_HI));
    m.neg = dir_neg;
    tick_cnt = tick_cnt + 1'b1;
    return m;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, restart: 1'b0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic row_t tick_row(input bit restart);
    row_t row;
    row = '{kind: ROW_TICK, idx: '0, data: '0, restart: restart, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic row_t tick_row_exp(input bit restart, input longint pos,
                                        input longint vel, input longint acc,
                                        input logic [PHASE_W-1:0] phase, input bit neg);
    row_t row;
    row = tick_row(restart);
    row.typed = 1'b1;
    row.want = '{pos: POS_W'(pos), vel: VEL_W'(vel), acc: VEL_W'(acc), phase: phase, neg: neg};
    return row;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(2))
      0: return POS_W'({$urandom, $urandom});
      1: return {{(POS_W-32){r[31]}}, r};
      default: return $urandom_range(1) ? POS_W'(POS_HI - longint'($urandom_range(1000)))
                                        : POS_W'(POS_LO + longint'($urandom_range(1000)));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    return $urandom_range(1) ? RATE_W'($urandom) : RATE_W'($urandom_range(0, 1 << 24));
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one tick item, with an optional idle gap in front of it, and
  // records the reference it must produce once it is accepted.
  task automatic send_tick(input bit restart, input bit typed, input motion_t typed_want);
    motion_t m;
    if ($urandom_range(99) < idle_pct) begin
      tick_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    tick_if.restart <= restart;
    tick_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!tick_if.ready);
    m = next_motion(restart);
    expected_refs.push_back(typed ? typed_want : m);
  endtask

  // Holds off the tick channel until every outstanding reference has arrived.
  task automatic wait_drained();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_refs.size() != 0);
  endtask

  // Writes one profile register; the caller lowers valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      ttg_pkg::CFG_FIRST_POSITION:  profile.first_position    = data[POS_W-1:0];
      ttg_pkg::CFG_SECOND_POSITION: profile.second_position   = data[POS_W-1:0];
      ttg_pkg::CFG_SPEED_PER_TICK:  profile.speed_per_tick    = data[RATE_W-1:0];
      ttg_pkg::CFG_ACCEL_PER_TICK:  profile.accel_per_tick_sq = data[RATE_W-1:0];
      ttg_pkg::CFG_RAMP_TICKS:      profile.ramp_ticks        = data[TIME_W-1:0];
      ttg_pkg::CFG_COAST_TICKS:     profile.coast_ticks       = data[TIME_W-1:0];
      ttg_pkg::CFG_REVERSE_TICKS:   profile.reverse_ticks     = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver ready, stalling at the rate of the current phase.
  initial begin
    ref_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      ref_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compares each accepted reference item with the oldest expectation.
  always @(posedge clk_i) begin
    motion_t want;
    if (rst_ni && ref_if.valid && ref_if.ready) begin
      if (expected_refs.size() == 0) begin
        $display("%0t ns: reference item arrived with none expected", $time);
        mismatches++;
      end else begin
        want = expected_refs.pop_front();
        check_field("ref_position", want.pos, ref_if.ref_position);
        check_field("ref_velocity", want.vel, ref_if.ref_velocity);
        check_field("ref_acceleration", want.acc, ref_if.ref_acceleration);
        check_field("phase", want.phase, ref_if.phase);
        check_field("moving_negative", want.neg, ref_if.moving_negative);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("trapezoidal_trajectory_generator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [POS_W-1:0]      pa, pb;
    logic [RATE_W-1:0]     speed, accel;
    logic [TIME_W-1:0]     ramp, coast, rev;
    logic [CFG_DATA_W-1:0] junk;
    bit cfg_open;
    cfg_open = 1'b0;

    rst_ni         <= 1'b0;
    tick_if.valid   <= 1'b0;
    tick_if.restart <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= ttg_pkg::CFG_FIRST_POSITION;
    cfg_if.data     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset defaults, restart mid-segment, extreme profile
    // with saturation and a reversal, rate saturation with floored coast
    // midpoints, zero ramp with zero reversal period, and all-zero rates.
    rows.push_back(tick_row_exp(1'b0, 0, 0, 67109, ttg_pkg::PHASE_ACCEL, 1'b0));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row_exp(1'b1, 0, 0, 67109, ttg_pkg::PHASE_ACCEL, 1'b0));
    rows.push_back(cfg_row(ttg_pkg::CFG_FIRST_POSITION, CFG_DATA_W'(POS_HI)));
    rows.push_back(cfg_row(ttg_pkg::CFG_SECOND_POSITION, CFG_DATA_W'(POS_LO)));
    rows.push_back(cfg_row(ttg_pkg::CFG_SPEED_PER_TICK, CFG_DATA_W'(V32_HI)));
    rows.push_back(cfg_row(ttg_pkg::CFG_ACCEL_PER_TICK, CFG_DATA_W'(V32_HI)));
    rows.push_back(cfg_row(ttg_pkg::CFG_RAMP_TICKS, 40'd1));
    rows.push_back(cfg_row(ttg_pkg::CFG_COAST_TICKS, 40'd0));
    rows.push_back(cfg_row(ttg_pkg::CFG_REVERSE_TICKS, 40'd4));
    rows.push_back(tick_row_exp(1'b1, POS_HI, 0, V32_HI, ttg_pkg::PHASE_ACCEL, 1'b0));
    rows.push_back(tick_row_exp(1'b0, POS_LO, V32_HI, -V32_HI, ttg_pkg::PHASE_DECEL, 1'b0));
    rows.push_back(tick_row_exp(1'b0, POS_LO, 0, 0, ttg_pkg::PHASE_REST, 1'b0));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row_exp(1'b0, POS_LO, 0, -V32_HI, ttg_pkg::PHASE_ACCEL, 1'b1));
    rows.push_back(tick_row_exp(1'b0, POS_HI, -V32_HI, V32_HI, ttg_pkg::PHASE_DECEL, 1'b1));
    rows.push_back(tick_row(1'b0));
    rows.push_back(cfg_row(ttg_pkg::CFG_FIRST_POSITION, CFG_DATA_W'(-64'sd20001)));
    rows.push_back(cfg_row(ttg_pkg::CFG_SECOND_POSITION, 40'd12344));
    rows.push_back(cfg_row(ttg_pkg::CFG_SPEED_PER_TICK, 40'd7));
    rows.push_back(cfg_row(ttg_pkg::CFG_RAMP_TICKS, 40'd3));
    rows.push_back(cfg_row(ttg_pkg::CFG_COAST_TICKS, 40'd2));
    rows.push_back(cfg_row(ttg_pkg::CFG_REVERSE_TICKS, 40'd20));
    for (int i = 0; i < 6; i++) rows.push_back(tick_row(i == 0));
    rows.push_back(cfg_row(ttg_pkg::CFG_RAMP_TICKS, 40'd0));
    rows.push_back(cfg_row(ttg_pkg::CFG_COAST_TICKS, 40'd3));
    rows.push_back(cfg_row(ttg_pkg::CFG_REVERSE_TICKS, 40'd0));
    for (int i = 0; i < 3; i++) rows.push_back(tick_row(i == 0));
    rows.push_back(cfg_row(ttg_pkg::CFG_SPEED_PER_TICK, 40'd0));
    rows.push_back(cfg_row(ttg_pkg::CFG_ACCEL_PER_TICK, 40'd0));
    rows.push_back(cfg_row(ttg_pkg::CFG_RAMP_TICKS, 40'd65535));
    rows.push_back(cfg_row(ttg_pkg::CFG_COAST_TICKS, 40'd65535));
    rows.push_back(cfg_row(ttg_pkg::CFG_REVERSE_TICKS, 40'd65535));
    rows.push_back(tick_row_exp(1'b1, -20001, 0, 0, ttg_pkg::PHASE_ACCEL, 1'b0));
    rows.push_back(tick_row(1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (!cfg_open) wait_drained();
        write_reg(rows[i].idx, rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_tick(rows[i].restart, rows[i].typed, rows[i].want);
      end
    end

    // Profiles, one per round, randomized except in rounds 3 and 7, under four idle and stall patterns.
    for (int round = 0; round < ROUNDS; round++) begin
      wait_drained();
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase

      if (round == 3) begin
        pa = POS_W'(POS_HI);
        pb = POS_W'(POS_LO);
        speed = '1;
        accel = '1;
        ramp = '1;
        coast = '1;
        rev = '1;
      end else if (round == 7) begin
        pa = '0;
        pb = '0;
        speed = '0;
        accel = '0;
        ramp = '0;
        coast = '0;
        rev = '0;
      end else begin
        // Short segments so that every phase and many reversals are reached.
        pa = pick_position();
        pb = pick_position();
        speed = pick_rate();
        accel = pick_rate();
        ramp = TIME_W'($urandom_range(0, 6));
        coast = TIME_W'($urandom_range(0, 8));
        rev = TIME_W'($urandom_range(0, 40));
      end

      // Unused upper data bits carry random values; the block must drop them.
      junk = CFG_DATA_W'({$urandom, $urandom});
      write_reg(ttg_pkg::CFG_FIRST_POSITION, pa);
      write_reg(ttg_pkg::CFG_SECOND_POSITION, pb);
      write_reg(ttg_pkg::CFG_SPEED_PER_TICK, {junk[CFG_DATA_W-1:RATE_W], speed});
      write_reg(ttg_pkg::CFG_ACCEL_PER_TICK, {junk[CFG_DATA_W-1:RATE_W], accel});
      write_reg(ttg_pkg::CFG_RAMP_TICKS, {junk[CFG_DATA_W-1:TIME_W], ramp});
      write_reg(ttg_pkg::CFG_COAST_TICKS, {junk[CFG_DATA_W-1:TIME_W], coast});
      write_reg(ttg_pkg::CFG_REVERSE_TICKS, {junk[CFG_DATA_W-1:TIME_W], rev});
      cfg_if.valid <= 1'b0;

      for (int n = 0; n < ROUND_TICKS; n++) begin
        if ($urandom_range(99) == 0) wait_drained();
        send_tick($urandom_range(99) < 3, 1'b0, '0);
      end
    end

    // Drain, then watch a while longer for stray reference items.
    tick_if.valid <= 1'b0;
    stall_pct = 0;
    do @(posedge clk_i); while (expected_refs.size() != 0);
    repeat (4 * TICK_LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_refs.size() == 0) begin
      $display("trapezoidal_trajectory_generator_tb OK");
    end else begin
      $display("trapezoidal_trajectory_generator_tb NOT OK");
    end
    $finish;
  end

endmodule
